>>> design/mtp_pkg.sv
// Shared types and constants for the MAC address text parser.
`timescale 1ns / 1ps
`default_nettype none
package mtp_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned CharWidth = 8;

  localparam logic [CharWidth-1:0] ColonChar = 8'h3a;
  // separator counter stops here, so an over-long text never matches
  localparam logic [3:0] OctetSat = 4'd9;
  // separators expected: octets minus one
  localparam logic [3:0] Eui48Seps = 4'd5;
  localparam logic [3:0] Eui64Seps = 4'd7;

  localparam logic [7:0] McastMask = 8'h01;
  localparam logic [7:0] LocalMask = 8'h02;

  typedef enum logic {
    ADDR_EUI48 = 1'b0,
    ADDR_EUI64 = 1'b1
  } addr_type_e;

  typedef struct packed {
    logic [1:0]           digit_count;
    logic [3:0]           sep_count;
    logic [AddrWidth-1:0] addr_shift;
    logic                 error_seen;
  } parse_state_t;

  typedef struct packed {
    logic                 addr_valid;
    logic [AddrWidth-1:0] address;
    logic                 is_multicast;
    logic                 is_local;
    logic                 is_broadcast;
  } result_t;

endpackage
`default_nettype wire

>>> design/mtp_if.sv
// Valid/ready channel interfaces for characters, results and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic        addr_valid;
  logic [63:0] address;
  logic        is_multicast;
  logic        is_local;
  logic        is_broadcast;

  modport source (output valid, output addr_valid, output address, output is_multicast,
                  output is_local, output is_broadcast, input ready);
  modport sink (input valid, input addr_valid, input address, input is_multicast,
                input is_local, input is_broadcast, output ready);
endinterface

interface mtp_cfg_if;
  logic valid;
  logic ready;
  logic address_type;

  modport source (output valid, output address_type, input ready);
  modport sink (input valid, input address_type, output ready);
endinterface
`default_nettype wire

>>> design/mtp_step.sv
// Per-character parse step: state update and result formation.
`timescale 1ns / 1ps
`default_nettype none
module mtp_step (
  input  mtp_pkg::parse_state_t state_i,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  input  logic                  address_type_i,
  output mtp_pkg::parse_state_t state_o,
  output mtp_pkg::result_t      result_o
);
  import mtp_pkg::*;

  logic         is_hex;
  logic [3:0]   nib;
  parse_state_t nxt;
  logic [3:0]   want_seps;
  logic         valid;
  logic [AddrWidth-1:0] addr;
  logic [7:0]   first;
  logic         all_ones;

  // hex digit decode, either case
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    priority if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      nib = char_code_i[3:0];
    end else if ((char_code_i >= 8'h61 && char_code_i <= 8'h66) ||
                 (char_code_i >= 8'h41 && char_code_i <= 8'h46)) begin
      nib = char_code_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    nxt = state_i;
    priority if (is_hex && state_i.digit_count < 2'd2) begin
      nxt.digit_count = state_i.digit_count + 2'd1;
      nxt.addr_shift  = {state_i.addr_shift[AddrWidth-5:0], nib};
    end else if (char_code_i == ColonChar && state_i.digit_count == 2'd2) begin
      nxt.digit_count = 2'd0;
      if (state_i.sep_count < OctetSat) begin
        nxt.sep_count = state_i.sep_count + 4'd1;
      end
    end else begin
      nxt.error_seen = 1'b1;
    end
  end

  always_comb begin
    want_seps = (addr_type_e'(address_type_i) == ADDR_EUI64) ? Eui64Seps : Eui48Seps;
    valid = !nxt.error_seen && nxt.digit_count == 2'd2 && nxt.sep_count == want_seps;
    if (addr_type_e'(address_type_i) == ADDR_EUI64) begin
      addr     = nxt.addr_shift;
      first    = nxt.addr_shift[63:56];
      all_ones = &nxt.addr_shift;
    end else begin
      addr     = {16'h0000, nxt.addr_shift[47:0]};
      first    = nxt.addr_shift[47:40];
      all_ones = &nxt.addr_shift[47:0];
    end
    result_o.addr_valid   = valid;
    result_o.address      = valid ? addr : '0;
    result_o.is_multicast = valid && ((first & McastMask) != 8'h00);
    result_o.is_local     = valid && ((first & LocalMask) != 8'h00);
    result_o.is_broadcast = valid && all_ones;
    // the last character closes the text and clears the parse
    state_o = is_last_i ? '0 : nxt;
  end

endmodule
`default_nettype wire

>>> design/mac_address_text_parser_unit.sv
// Top level of the MAC address text parser (EUI-48 / EUI-64).
// Path: an accepted character beat goes to the input register; a last beat waits
// there while the result slot is full, then its result is visible until taken.
// Throughput: one character per cycle otherwise; the parse state update in mtp_step
// is the single combinational stage between the input and result registers.
// Reset: rst_ni clears parse state, both valid flags and address_type (EUI-48).
`timescale 1ns / 1ps
`default_nettype none
module mac_address_text_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtp_in_if.sink          in_i,
  mtp_out_if.source       out_o,
  mtp_cfg_if.sink         cfg_i
);
  import mtp_pkg::*;

  // input register: one character beat
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_go;

  // running parse state
  parse_state_t state_q, state_d;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  // configuration
  logic addr_type_q;

  // A non-last beat never needs the result slot; a last beat needs the slot
  // empty or being emptied this cycle.
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign cfg_i.ready = 1'b1;

  mtp_step u_step (
    .state_i        (state_q),
    .char_code_i    (s1_char_q),
    .is_last_i      (s1_last_q),
    .address_type_i (addr_type_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // character payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_char_q <= in_i.char_code;
      s1_last_q <= in_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_type_q <= ADDR_EUI48;
    end else if (cfg_i.valid && cfg_i.ready) begin
      addr_type_q <= cfg_i.address_type;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.addr_valid   = res_q.addr_valid;
  assign out_o.address      = res_q.address;
  assign out_o.is_multicast = res_q.is_multicast;
  assign out_o.is_local     = res_q.is_local;
  assign out_o.is_broadcast = res_q.is_broadcast;

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking bench for the MAC address text parser: random and directed address texts.
`timescale 1ns / 1ps
module tb_top;
  import mtp_pkg::*;

  // Run shape
  localparam int unsigned CycleLimit = 200000;  // far above the slowest legal run
  localparam int unsigned PhaseChars = 205;     // characters per random phase, at least
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned DrainCycles = 4;      // idle wait after every owed result is taken
  localparam int unsigned HoldAtResult = 20;    // result count that arms the long stall
  localparam int unsigned HoldCycles = 300;
  localparam logic [4:0]  NotHex = 5'h10;

  // Ways a well-formed text gets broken
  typedef enum logic [2:0] {
    FLAW_REPLACE,   // one character swapped for any byte
    FLAW_EXTRA_HEX, // a third digit lands in some octet
    FLAW_DROP,      // one character removed
    FLAW_TRAIL_SEP, // colon after the final octet
    FLAW_STRAY_SEP  // colon in a random place
  } flaw_e;

  // Golden parser plus the queue of results it owes
  class addr_scoreboard;
    addr_type_e  addr_type = ADDR_EUI48;
    logic [1:0]  digit_count = '0;
    logic [3:0]  sep_count = '0;
    logic [63:0] addr_shift = '0;
    bit          error_seen = 1'b0;
    result_t     owed_q[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned valid_seen = 0;
    int unsigned bcast_seen = 0;
    int unsigned mcast_seen = 0;
    int unsigned local_seen = 0;

    function void set_type(addr_type_e t);
      addr_type = t;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function logic [4:0] decode_hex(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return NotHex;
    endfunction

    // One accepted character beat
    function void note_char(logic [7:0] c, bit last);
      logic [4:0] nib;
      logic [3:0] want_seps;
      logic [7:0] first;
      result_t    res;
      nib = decode_hex(c);
      if (!nib[4] && digit_count < 2'd2) begin
        digit_count++;
        addr_shift = {addr_shift[59:0], nib[3:0]};
      end else if (c == ColonChar && digit_count == 2'd2) begin
        digit_count = '0;
        if (sep_count < OctetSat) sep_count++;
      end else begin
        error_seen = 1'b1;
      end
      if (!last) return;
      want_seps = (addr_type == ADDR_EUI64) ? Eui64Seps : Eui48Seps;
      res = '0;
      if (!error_seen && digit_count == 2'd2 && sep_count == want_seps) begin
        res.addr_valid = 1'b1;
        if (addr_type == ADDR_EUI64) begin
          res.address = addr_shift;
          first = addr_shift[63:56];
          res.is_broadcast = &addr_shift;
        end else begin
          res.address = {16'h0, addr_shift[47:0]};
          first = addr_shift[47:40];
          res.is_broadcast = &addr_shift[47:0];
        end
        res.is_multicast = |(first & McastMask);
        res.is_local = |(first & LocalMask);
      end
      owed_q.push_back(res);
      digit_count = '0;
      sep_count = '0;
      addr_shift = '0;
      error_seen = 1'b0;
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    // One accepted result beat
    function void check_result(result_t got);
      result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing outstanding (address 0x%0h)", got.address);
        mismatches++;
        return;
      end
      exp_r = owed_q.pop_front();
      results_seen++;
      valid_seen += exp_r.addr_valid;
      bcast_seen += exp_r.is_broadcast;
      mcast_seen += exp_r.is_multicast;
      local_seen += exp_r.is_local;
      field_check("addr_valid", 64'(exp_r.addr_valid), 64'(got.addr_valid));
      field_check("address", exp_r.address, got.address);
      field_check("is_multicast", 64'(exp_r.is_multicast), 64'(got.is_multicast));
      field_check("is_local", 64'(exp_r.is_local), 64'(got.is_local));
      field_check("is_broadcast", 64'(exp_r.is_broadcast), 64'(got.is_broadcast));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;   // high: neither side idles
  int unsigned cycles = 0;
  int unsigned chars_sent = 0;
  logic [7:0] text_q[$];
  addr_scoreboard pred = new;

  addr_type_e phase_types[NumPhases] = '{ADDR_EUI64, ADDR_EUI48, ADDR_EUI64,
                                         ADDR_EUI48, ADDR_EUI64};
  // Short special cases first, then one full broadcast address
  string directed_texts[6] = '{"1", ":", "abc", "g", "12:", "FF:ff:FF:ff:FF:ff"};

  mtp_in_if  in_if ();
  mtp_out_if out_if ();
  mtp_cfg_if cfg_if ();

  mac_address_text_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hex digit character for a nibble, letters in random case
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
  endfunction

  // Fills text_q with one address text: mostly well-formed, some broken, some noise
  task automatic build_random_text(addr_type_e t);
    int unsigned kind;
    int unsigned n_oct;
    int unsigned pick;
    int unsigned pos;
    bit          all_ff;
    logic [7:0]  octet;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      // noise: arbitrary bytes with separators and digits mixed in
      repeat ($urandom_range(1, 20)) begin
        pick = $urandom_range(3);
        if (pick < 2) text_q.push_back(8'($urandom_range(255)));
        else if (pick == 2) text_q.push_back(ColonChar);
        else text_q.push_back(hex_char(4'($urandom_range(15))));
      end
      return;
    end
    pick = $urandom_range(99);
    if (pick < 60) n_oct = (t == ADDR_EUI64) ? 8 : 6;
    else if (pick < 80) n_oct = (t == ADDR_EUI64) ? 6 : 8;
    else n_oct = $urandom_range(1, 11);  // short, long and past saturation
    all_ff = ($urandom_range(9) == 0);
    for (int i = 0; i < n_oct; i++) begin
      if (i != 0) text_q.push_back(ColonChar);
      octet = all_ff ? 8'hff : 8'($urandom_range(255));
      text_q.push_back(hex_char(octet[7:4]));
      text_q.push_back(hex_char(octet[3:0]));
    end
    if (kind < 80) return;
    pos = $urandom_range(text_q.size() - 1);
    case (flaw_e'($urandom_range(4)))
      FLAW_REPLACE: begin
        text_q[pos] = 8'($urandom_range(255));
      end
      FLAW_EXTRA_HEX: begin
        text_q.insert(pos, hex_char(4'($urandom_range(15))));
      end
      FLAW_DROP: begin
        text_q.delete(pos);
        if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
      end
      FLAW_TRAIL_SEP: begin
        text_q.push_back(ColonChar);
      end
      default: begin
        text_q.insert(pos, ColonChar);
      end
    endcase
  endtask

  // One character beat; random idle cycles before it unless steady
  task automatic send_char(logic [7:0] c, bit last);
    while (!steady && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= c;
    in_if.is_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    pred.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  // Sender stops until every owed result is taken, then waits out the pipeline
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_addr_type(addr_type_e t);
    cfg_if.valid <= 1'b1;
    cfg_if.address_type <= t;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pred.set_type(t);
  endtask

  // Result side: random back-pressure plus one long hold-off, started while
  // the sender is offering, so the output register fills and the input stalls
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned taken;
    bit          held;
    result_t     got;
    hold_left = 0;
    taken = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.addr_valid = out_if.addr_valid;
        got.address = out_if.address;
        got.is_multicast = out_if.is_multicast;
        got.is_local = out_if.is_local;
        got.is_broadcast = out_if.is_broadcast;
        pred.check_result(got);
        taken++;
        if (!held && taken >= HoldAtResult && in_if.valid) begin
          hold_left = HoldCycles;
          held = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.is_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.address_type = ADDR_EUI48;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone digit, lone colon, third digit, bad char, trailing
    // colon, then the all-ones EUI-48 address
    write_addr_type(ADDR_EUI48);
    foreach (directed_texts[d]) begin
      text_q.delete();
      for (int i = 0; i < directed_texts[d].len(); i++) text_q.push_back(directed_texts[d][i]);
      send_text();
    end

    // Random phases, type flipped between them; middle phase runs without idling
    for (int p = 0; p < NumPhases; p++) begin
      int unsigned phase_start;
      settle();
      steady <= (p == 2);
      write_addr_type(phase_types[p]);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars) begin
        build_random_text(phase_types[p]);
        send_text();
      end
    end
    settle();

    $display("Sent %0d characters over both address types; %0d results checked.",
             chars_sent, pred.results_seen);
    $display("Of those %0d parsed, %0d broadcast, %0d multicast, %0d locally administered.",
             pred.valid_seen, pred.bcast_seen, pred.mcast_seen, pred.local_seen);
    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
